FILE: hdl/sad_pkg.sv
package sad_pkg;

   localparam int KEY_W       = 32;
   localparam int BLK_W       = 32;
   localparam int FORK_W      = 2;
   localparam int LIMIT_W     = 7;
   localparam int THRESH_W    = 31;
   localparam int RATIO_W     = 17;
   localparam int MINTOT_W    = 31;
   localparam int COUNT_W     = 31;
   localparam int STAMP_W     = 64;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int Q16_SHIFT   = 16;

   localparam int DEFAULT_DEPTH = 64;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd64;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1024;
   localparam logic [RATIO_W-1:0]  RATIO_RESET  = 17'd58982;
   localparam logic [MINTOT_W-1:0] MINTOT_RESET = 31'd10;
   localparam logic [RATIO_W-1:0]  RATIO_ONE    = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINTOT = 8'd3;

   typedef struct packed {
      logic [LIMIT_W-1:0]  limit;
      logic [THRESH_W-1:0] thresh;
      logic [RATIO_W-1:0]  ratio;
      logic [MINTOT_W-1:0] mintot;
   } cfg_type;

   typedef struct packed {
      logic              bypass;
      logic [KEY_W-1:0]  rel;
      logic [KEY_W-1:0]  spc;
      logic [KEY_W-1:0]  db;
      logic [BLK_W-1:0]  blk;
   } item_type;

   typedef struct packed {
      logic [KEY_W-1:0]   rel;
      logic [KEY_W-1:0]   spc;
      logic [KEY_W-1:0]   db;
      logic [BLK_W-1:0]   last;
      logic [COUNT_W-1:0] seq;
      logic [COUNT_W-1:0] rnd;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MULT,
      ST_COMMIT,
      ST_REPORT
   } back_state_type;

endpackage

FILE: hdl/sad_req_if.sv
interface sad_req_if;
   logic                         valid;
   logic                         ready;
   logic [sad_pkg::KEY_W-1:0]    relation_id;
   logic [sad_pkg::KEY_W-1:0]    tablespace_id;
   logic [sad_pkg::KEY_W-1:0]    database_id;
   logic [sad_pkg::FORK_W-1:0]   fork_number;
   logic [sad_pkg::BLK_W-1:0]    block_number;

   modport source (output valid, relation_id, tablespace_id, database_id, fork_number,
                   block_number, input ready);
   modport sink   (input valid, relation_id, tablespace_id, database_id, fork_number,
                   block_number, output ready);
endinterface

FILE: hdl/sad_rsp_if.sv
interface sad_rsp_if;
   logic valid;
   logic ready;
   logic is_sequential;
   logic entry_found;

   modport source (output valid, is_sequential, entry_found, input ready);
   modport sink   (input valid, is_sequential, entry_found, output ready);
endinterface

FILE: hdl/sad_csr_if.sv
interface sad_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sad_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [sad_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: hdl/sad_ram.sv
module sad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

FILE: hdl/sad_front.sv
module sad_front (
   input  logic              clock,
   input  logic              reset,
   sad_req_if.sink           req_ch,
   input  logic              limit_zero,
   output logic              q_valid,
   input  logic              q_ready,
   output sad_pkg::item_type q_item
);

   sad_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;
   sad_pkg::item_type word;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign pop          = q_valid && q_ready;
   assign q_item       = slot_ff[rd_ptr_ff];

   // classify: other forks and a disabled table go straight through
   always_comb begin
      word.bypass = (req_ch.fork_number != '0) || limit_zero;
      word.rel    = req_ch.relation_id;
      word.spc    = req_ch.tablespace_id;
      word.db     = req_ch.database_id;
      word.blk    = req_ch.block_number;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

FILE: hdl/sad_back.sv
module sad_back #(
   parameter int DEPTH = sad_pkg::DEFAULT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sad_pkg::cfg_type                   cfg,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  sad_pkg::item_type                  q_item,
   sad_rsp_if.source                          rsp_ch,
   output logic [$clog2(DEPTH+1)-1:0]         occupied,
   output logic [DEPTH-1:0]                   slot_valid
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > sad_pkg::LIMIT_W) ? CW : sad_pkg::LIMIT_W;
   localparam int SW = sad_pkg::COUNT_W + 1;
   localparam int PW = sad_pkg::RATIO_W + SW;
   localparam int EW = $bits(sad_pkg::entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   sad_pkg::back_state_type state_ff, state_in;
   sad_pkg::item_type       item_ff, item_in;
   logic [IW-1:0]           addr_ff, addr_in;
   logic                    issue_ff, issue_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [IW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    rd_last_ff, rd_last_in;
   logic                    hit_ff, hit_in;
   logic [IW-1:0]           hit_idx_ff, hit_idx_in;
   sad_pkg::entry_type      hit_e_ff, hit_e_in;
   logic                    min_found_ff, min_found_in;
   logic [IW-1:0]           min_idx_ff, min_idx_in;
   logic [sad_pkg::STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic                    free_found_ff, free_found_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [CW-1:0]           occ_ff, occ_in;
   logic [sad_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic [sad_pkg::COUNT_W-1:0] seq_ff, seq_in;
   logic [sad_pkg::COUNT_W-1:0] rnd_ff, rnd_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic                    sum_ok_ff, sum_ok_in;
   logic                    res_seq_ff, res_seq_in;
   logic                    res_found_ff, res_found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_seq_ff, rsp_seq_in;
   logic                    rsp_found_ff, rsp_found_in;

   logic                    ram_we;
   logic [IW-1:0]           ram_waddr;
   sad_pkg::entry_type      ram_wentry;
   sad_pkg::entry_type      ram_rentry;
   logic [EW-1:0]           ram_rdata;

   logic                    out_free;
   logic                    evict_need;
   logic                    key_match;
   logic [LW-1:0]           limit_eff;
   logic [sad_pkg::RATIO_W-1:0] ratio_c;
   logic [SW-1:0]           sum_old, sum_new;
   logic [sad_pkg::COUNT_W-1:0] seq_h, rnd_h;

   sad_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wentry),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign ram_rentry    = ram_rdata;
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign q_ready       = (state_ff == sad_pkg::ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.is_sequential = rsp_seq_ff;
   assign rsp_ch.entry_found   = rsp_found_ff;
   assign occupied      = occ_ff;
   assign slot_valid    = valid_ff;

   assign limit_eff  = (LW'(cfg.limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cfg.limit);
   assign evict_need = (LW'(occ_ff) >= limit_eff);
   assign ratio_c    = (cfg.ratio > sad_pkg::RATIO_ONE) ? sad_pkg::RATIO_ONE : cfg.ratio;
   assign key_match  = (ram_rentry.rel == item_ff.rel) && (ram_rentry.spc == item_ff.spc) &&
                       (ram_rentry.db == item_ff.db);
   assign sum_old    = SW'(hit_e_ff.seq) + SW'(hit_e_ff.rnd);
   assign sum_new    = SW'(seq_ff) + SW'(rnd_ff);
   assign seq_h      = (sum_old >= SW'(cfg.thresh)) ? (hit_e_ff.seq >> 1) : hit_e_ff.seq;
   assign rnd_h      = (sum_old >= SW'(cfg.thresh)) ? (hit_e_ff.rnd >> 1) : hit_e_ff.rnd;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sad_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = q_item.bypass ? sad_pkg::ST_REPORT : sad_pkg::ST_SCAN;
            end
         end
         sad_pkg::ST_SCAN: begin
            if (rd_pend_ff && rd_last_ff) begin
               state_in = sad_pkg::ST_DECIDE;
            end
         end
         sad_pkg::ST_DECIDE: begin
            if (hit_ff) begin
               state_in = sad_pkg::ST_MULT;
            end else if (evict_need) begin
               state_in = sad_pkg::ST_SCAN;
            end else begin
               state_in = sad_pkg::ST_REPORT;
            end
         end
         sad_pkg::ST_MULT:   state_in = sad_pkg::ST_COMMIT;
         sad_pkg::ST_COMMIT: state_in = sad_pkg::ST_REPORT;
         sad_pkg::ST_REPORT: begin
            if (out_free) begin
               state_in = sad_pkg::ST_IDLE;
            end
         end
         default: state_in = sad_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_last_in    = rd_last_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_e_in      = hit_e_ff;
      min_found_in  = min_found_ff;
      min_idx_in    = min_idx_ff;
      min_stamp_in  = min_stamp_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      stamp_in      = stamp_ff;
      seq_in        = seq_ff;
      rnd_in        = rnd_ff;
      prod_in       = prod_ff;
      sum_ok_in     = sum_ok_ff;
      res_seq_in    = res_seq_ff;
      res_found_in  = res_found_ff;
      ram_we        = 1'b0;
      ram_waddr     = hit_idx_ff;
      ram_wentry.rel   = item_ff.rel;
      ram_wentry.spc   = item_ff.spc;
      ram_wentry.db    = item_ff.db;
      ram_wentry.last  = item_ff.blk;
      ram_wentry.seq   = seq_ff;
      ram_wentry.rnd   = rnd_ff;
      ram_wentry.stamp = stamp_ff;

      unique case (state_ff)
         sad_pkg::ST_IDLE: begin
            if (q_valid) begin
               item_in       = q_item;
               res_seq_in    = 1'b0;
               res_found_in  = 1'b0;
               addr_in       = '0;
               issue_in      = 1'b1;
               hit_in        = 1'b0;
               min_found_in  = 1'b0;
               free_found_in = 1'b0;
            end
         end
         sad_pkg::ST_SCAN: begin
            if (issue_ff) begin
               rd_pend_in = 1'b1;
               rd_idx_in  = addr_ff;
               rd_last_in = (addr_ff == LAST_IDX);
               addr_in    = addr_ff + 1'b1;
               issue_in   = (addr_ff != LAST_IDX);
            end
            if (rd_pend_ff) begin
               if (valid_ff[rd_idx_ff]) begin
                  if (key_match && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = rd_idx_ff;
                     hit_e_in   = ram_rentry;
                  end
                  if (!min_found_ff || (ram_rentry.stamp < min_stamp_ff)) begin
                     min_found_in = 1'b1;
                     min_idx_in   = rd_idx_ff;
                     min_stamp_in = ram_rentry.stamp;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
            end
         end
         sad_pkg::ST_DECIDE: begin
            if (hit_ff) begin
               if (hit_e_ff.last + 1'b1 == item_ff.blk) begin
                  seq_in = seq_h + 1'b1;
                  rnd_in = rnd_h;
               end else begin
                  seq_in = seq_h;
                  rnd_in = rnd_h + 1'b1;
               end
            end else if (evict_need) begin
               // drop the least recent entry and look again
               valid_in[min_idx_ff] = 1'b0;
               occ_in        = occ_ff - 1'b1;
               addr_in       = '0;
               issue_in      = 1'b1;
               min_found_in  = 1'b0;
               free_found_in = 1'b0;
            end else begin
               ram_we           = 1'b1;
               ram_waddr        = free_idx_ff;
               ram_wentry.seq   = '0;
               ram_wentry.rnd   = '0;
               valid_in[free_idx_ff] = 1'b1;
               occ_in           = occ_ff + 1'b1;
               stamp_in         = stamp_ff + 1'b1;
            end
         end
         sad_pkg::ST_MULT: begin
            prod_in   = PW'(ratio_c) * PW'(sum_new);
            sum_ok_in = (sum_new >= SW'(cfg.mintot));
         end
         sad_pkg::ST_COMMIT: begin
            ram_we       = 1'b1;
            stamp_in     = stamp_ff + 1'b1;
            res_found_in = 1'b1;
            res_seq_in   = sum_ok_ff &&
                           (PW'({seq_ff, {sad_pkg::Q16_SHIFT{1'b0}}}) >= prod_ff);
         end
         sad_pkg::ST_REPORT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_seq_in   = rsp_seq_ff;
      rsp_found_in = rsp_found_ff;
      if ((state_ff == sad_pkg::ST_REPORT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_seq_in   = res_seq_ff;
         rsp_found_in = res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sad_pkg::ST_IDLE;
         issue_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      rd_last_ff    <= rd_last_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_e_ff      <= hit_e_in;
      min_found_ff  <= min_found_in;
      min_idx_ff    <= min_idx_in;
      min_stamp_ff  <= min_stamp_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      seq_ff        <= seq_in;
      rnd_ff        <= rnd_in;
      prod_ff       <= prod_in;
      sum_ok_ff     <= sum_ok_in;
      res_seq_ff    <= res_seq_in;
      res_found_ff  <= res_found_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_found_ff  <= rsp_found_in;
   end

endmodule

FILE: hdl/sequential_access_detector_core.sv
// sequential access detector: one block access word in, one verdict word out
// req_ch carries the relation key (three ids), the fork number and the block
// number; rsp_ch returns is_sequential and entry_found, in request order
// csr_ch writes the four registers (limit, halving threshold, Q16 ratio,
// least total count); it is always ready and is meant to be used while idle
// a two-word queue splits the front (accept, classify) from the back, which
// looks the key up by reading every table entry from one RAM port in turn
// other forks and a zero limit skip the table; a miss scans every entry and
// then writes a free slot, a hit scans and then passes DECIDE, MULT and COMMIT;
// each least-recent entry evicted on a full table adds another full scan
// the back takes the next queued word only after reporting the last one
// reset empties the table (valid bits only, no clearing pass) and loads the
// register defaults 64, 1024, 58982 and 10
// a stalled rsp_ch holds its word; the back waits and the queue takes up to
// two more requests before req_ch.ready drops
module sequential_access_detector_core #(
   parameter int TABLE_DEPTH = sad_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   sad_req_if.sink   req_ch,
   sad_rsp_if.source rsp_ch,
   sad_csr_if.sink   csr_ch
);

   sad_pkg::cfg_type              cfg_ff, cfg_in;
   logic                          q_valid;
   logic                          q_ready;
   sad_pkg::item_type             q_item;
   logic [$clog2(TABLE_DEPTH+1)-1:0] occupied;
   logic [TABLE_DEPTH-1:0]        slot_valid;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            sad_pkg::CSR_LIMIT:  cfg_in.limit  = csr_ch.wdata[sad_pkg::LIMIT_W-1:0];
            sad_pkg::CSR_THRESH: cfg_in.thresh = csr_ch.wdata[sad_pkg::THRESH_W-1:0];
            sad_pkg::CSR_RATIO:  cfg_in.ratio  = csr_ch.wdata[sad_pkg::RATIO_W-1:0];
            sad_pkg::CSR_MINTOT: cfg_in.mintot = csr_ch.wdata[sad_pkg::MINTOT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit  <= sad_pkg::LIMIT_RESET;
         cfg_ff.thresh <= sad_pkg::THRESH_RESET;
         cfg_ff.ratio  <= sad_pkg::RATIO_RESET;
         cfg_ff.mintot <= sad_pkg::MINTOT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sad_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .limit_zero (cfg_ff.limit == '0),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   sad_back #(.DEPTH(TABLE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_ch     (rsp_ch),
      .occupied   (occupied),
      .slot_valid (slot_valid)
   );

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid) == occupied)
      else $error("occupancy differs from valid bits");

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occupied <= TABLE_DEPTH)
      else $error("occupancy above table depth");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (occupied == '0) && (slot_valid == '0))
      else $error("table not empty after reset");

   a_one_change: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid ^ $past(slot_valid)) <= 1)
      else $error("more than one slot changed in a cycle");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int DEPTH = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int POOL_N = 96;

   typedef struct {
      logic seq;
      logic found;
   } verdict_type;

   typedef struct {
      logic [31:0] rel;
      logic [31:0] spc;
      logic [31:0] db;
      logic [1:0]  fork_no;
      logic [31:0] blk;
      bit          typed;
      logic        seq;
      logic        found;
   } row_type;

   typedef struct {
      logic [6:0]  limit;
      logic [30:0] thresh;
      logic [16:0] ratio;
      logic [30:0] mintot;
      int          items;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sad_req_if req_ch ();
   sad_rsp_if rsp_ch ();
   sad_csr_if csr_ch ();

   sequential_access_detector_core #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // table shadow
   bit          tbl_valid [DEPTH];
   logic [31:0] tbl_rel   [DEPTH];
   logic [31:0] tbl_spc   [DEPTH];
   logic [31:0] tbl_db    [DEPTH];
   logic [31:0] tbl_last  [DEPTH];
   logic [31:0] tbl_seq   [DEPTH];
   logic [31:0] tbl_rnd   [DEPTH];
   logic [63:0] tbl_total [DEPTH];
   int unsigned tbl_rank  [DEPTH];
   int unsigned tbl_used;

   logic [6:0]  cfg_limit  = sad_pkg::LIMIT_RESET;
   logic [30:0] cfg_thresh = sad_pkg::THRESH_RESET;
   logic [16:0] cfg_ratio  = sad_pkg::RATIO_RESET;
   logic [30:0] cfg_mintot = sad_pkg::MINTOT_RESET;

   verdict_type verdict_q [$];
   int  errors;
   int  cycles = 0;
   int  words_in;
   int  words_out;
   int  hits_seen;
   int  seq_seen;
   bit  calm;

   task automatic report(input string msg);
      $display("mismatch @%0d: %s", cycles, msg);
      errors++;
   endtask

   function automatic void drop_oldest();
      for (int i = 0; i < DEPTH; i++) begin
         if (tbl_valid[i]) begin
            if (tbl_rank[i] == 0) tbl_valid[i] = 1'b0;
            else tbl_rank[i]--;
         end
      end
      if (tbl_used > 0) tbl_used--;
   endfunction

   function automatic verdict_type classify_access(input logic [31:0] rel, spc, db,
                                                   input logic [1:0] fork_no,
                                                   input logic [31:0] blk);
      verdict_type v;
      int unsigned lim;
      int hit;
      int s;
      longint unsigned sum;
      longint unsigned ratio;
      v.seq = 1'b0;
      v.found = 1'b0;
      hit = -1;
      lim = (cfg_limit > DEPTH) ? DEPTH : cfg_limit;
      if (fork_no != 2'd0 || lim == 0) return v;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_rel[i] == rel && tbl_spc[i] == spc &&
             tbl_db[i] == db) hit = i;
      end
      if (hit >= 0) begin
         ratio = (cfg_ratio > 17'd65536) ? 64'd65536 : cfg_ratio;
         sum = longint'(tbl_seq[hit]) + tbl_rnd[hit];
         if (sum >= cfg_thresh) begin
            tbl_seq[hit] = tbl_seq[hit] >> 1;
            tbl_rnd[hit] = tbl_rnd[hit] >> 1;
         end
         if (tbl_last[hit] + 32'd1 == blk) tbl_seq[hit]++;
         else tbl_rnd[hit]++;
         tbl_total[hit]++;
         sum = longint'(tbl_seq[hit]) + tbl_rnd[hit];
         v.seq = (sum >= cfg_mintot) && ((longint'(tbl_seq[hit]) << 16) >= ratio * sum);
         v.found = 1'b1;
         for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && i != hit && tbl_rank[i] > tbl_rank[hit]) tbl_rank[i]--;
         tbl_rank[hit] = tbl_used - 1;
         tbl_last[hit] = blk;
         return v;
      end
      while (tbl_used >= lim) drop_oldest();
      s = 0;
      while (s < DEPTH && tbl_valid[s]) s++;
      tbl_valid[s] = 1'b1;
      tbl_rel[s] = rel;
      tbl_spc[s] = spc;
      tbl_db[s] = db;
      tbl_last[s] = blk;
      tbl_seq[s] = '0;
      tbl_rnd[s] = '0;
      tbl_total[s] = 64'd1;
      tbl_rank[s] = tbl_used;
      tbl_used++;
      return v;
   endfunction

   // one request word; caller is at a falling edge
   task automatic send_access(input logic [31:0] rel, spc, db, input logic [1:0] fork_no,
                              input logic [31:0] blk, input bit typed = 0,
                              input logic exp_seq = 0, input logic exp_found = 0);
      verdict_type v;
      while (!calm && $urandom_range(99) < 24) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.relation_id = rel;
      req_ch.tablespace_id = spc;
      req_ch.database_id = db;
      req_ch.fork_number = fork_no;
      req_ch.block_number = blk;
      do @(posedge clock); while (!req_ch.ready);
      v = classify_access(rel, spc, db, fork_no, blk);
      if (typed) begin
         v.seq = exp_seq;
         v.found = exp_found;
      end
      verdict_q.push_back(v);
      words_in++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.reg_index = idx;
      csr_ch.wdata = data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         sad_pkg::CSR_LIMIT:  cfg_limit = data[6:0];
         sad_pkg::CSR_THRESH: cfg_thresh = data[30:0];
         sad_pkg::CSR_RATIO:  cfg_ratio = data[16:0];
         sad_pkg::CSR_MINTOT: cfg_mintot = data[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // result side
   always @(negedge clock) begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      verdict_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_out++;
         if (verdict_q.size() == 0) begin
            report("verdict word with nothing expected");
         end else begin
            e = verdict_q.pop_front();
            if (rsp_ch.entry_found !== e.found)
               report($sformatf("entry_found %b, want %b (word %0d)", rsp_ch.entry_found,
                                e.found, words_out));
            if (rsp_ch.is_sequential !== e.seq)
               report($sformatf("is_sequential %b, want %b (word %0d)", rsp_ch.is_sequential,
                                e.seq, words_out));
            if (e.found) hits_seen++;
            if (e.seq) seq_seen++;
         end
      end
   end

   row_type   rows [$];
   phase_type phases [$];
   logic [31:0] pool_rel [POOL_N];
   logic [31:0] pool_spc [POOL_N];
   logic [31:0] pool_db  [POOL_N];
   logic [31:0] pool_next [POOL_N];

   initial begin
      int counted;
      int k;
      int span;
      int pick;
      logic [1:0]  f;
      logic [31:0] b;

      req_ch.valid = 1'b0;
      req_ch.relation_id = '0;
      req_ch.tablespace_id = '0;
      req_ch.database_id = '0;
      req_ch.fork_number = '0;
      req_ch.block_number = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wdata = '0;
      calm = 1'b0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      hits_seen = 0;
      seq_seen = 0;
      tbl_used = 0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

      // other forks, key extremes, block wrap, count and ratio edge
      rows.push_back('{32'h1, 32'h2, 32'h3, 2'd1, 32'h0, 1'b1, 1'b0, 1'b0});
      rows.push_back('{32'h1, 32'h2, 32'h3, 2'd2, 32'h5, 1'b1, 1'b0, 1'b0});
      rows.push_back('{'1, '1, '1, 2'd3, '1, 1'b1, 1'b0, 1'b0});
      rows.push_back('{'1, '1, '1, 2'd0, '1, 1'b1, 1'b0, 1'b0});
      rows.push_back('{'1, '1, '1, 2'd0, 32'h0, 1'b1, 1'b0, 1'b1});
      rows.push_back('{'0, '0, '0, 2'd0, 32'h0, 1'b1, 1'b0, 1'b0});
      rows.push_back('{'0, '0, '0, 2'd3, 32'h1, 1'b1, 1'b0, 1'b0});
      for (int i = 1; i <= 9; i++)
         rows.push_back('{'0, '0, '0, 2'd0, 32'(i), 1'b0, 1'b0, 1'b0});
      rows.push_back('{'0, '0, '0, 2'd0, 32'd10, 1'b1, 1'b1, 1'b1});
      rows.push_back('{'0, '0, '0, 2'd0, 32'd500, 1'b0, 1'b0, 1'b0});
      rows.push_back('{'0, '0, '1, 2'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b0});
      rows.push_back('{32'h5a5a5a5a, 32'ha5a5a5a5, 32'h0f0f0f0f, 2'd0, 32'h1,
                       1'b1, 1'b0, 1'b0});
      rows.push_back('{32'h5a5a5a5a, 32'ha5a5a5a5, 32'h0f0f0f0f, 2'd0, 32'h2,
                       1'b0, 1'b0, 1'b0});

      phases.push_back('{7'd64, 31'd1024, 17'd58982, 31'd10, 140});
      phases.push_back('{7'd1, 31'd4, 17'd32768, 31'd2, 110});
      phases.push_back('{7'd127, 31'd0, 17'd65536, 31'd0, 150});
      phases.push_back('{7'd0, 31'd7, 17'd1000, 31'd1, 30});
      phases.push_back('{7'd8, 31'd16, 17'd131071, 31'd1, 140});
      phases.push_back('{7'd64, 31'h7fffffff, 17'd0, 31'h7fffffff, 140});
      phases.push_back('{7'd3, 31'd2, 17'd45000, 31'd3, 140});
      phases.push_back('{7'd64, 31'd8, 17'd52000, 31'd4, 150});
      phases.push_back('{7'd32, 31'd1, 17'd65535, 31'd1, 140});
      phases.push_back('{7'd65, 31'd1024, 17'd58982, 31'd10, 100});

      for (int i = 0; i < POOL_N; i++) begin
         pool_rel[i] = $urandom();
         pool_spc[i] = $urandom();
         pool_db[i] = $urandom();
         pool_next[i] = $urandom();
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_access(rows[i].rel, rows[i].spc, rows[i].db, rows[i].fork_no, rows[i].blk,
                     rows[i].typed, rows[i].seq, rows[i].found);

      foreach (phases[p]) begin
         drain();
         write_reg(sad_pkg::CSR_LIMIT, 32'(phases[p].limit));
         write_reg(sad_pkg::CSR_THRESH, 32'(phases[p].thresh));
         write_reg(sad_pkg::CSR_RATIO, 32'(phases[p].ratio));
         write_reg(sad_pkg::CSR_MINTOT, 32'(phases[p].mintot));
         calm = (p == 7);
         counted = 0;
         while (counted < phases[p].items) begin
            k = $urandom_range(99);
            f = 2'd0;
            if (k < 6) begin
               pick = $urandom_range(POOL_N - 1);
               pool_rel[pick] = $urandom();
               pool_spc[pick] = $urandom();
               pool_db[pick] = $urandom();
               pool_next[pick] = $urandom();
            end else begin
               k = $urandom_range(9);
               span = (k < 5) ? ((cfg_limit > 0 && cfg_limit < 16) ? cfg_limit + 1 : 4)
                    : (k < 8) ? 20 : POOL_N;
               pick = $urandom_range(span - 1);
            end
            if ($urandom_range(99) < 8) f = 2'($urandom_range(3, 1));
            k = $urandom_range(99);
            b = (k < 80) ? pool_next[pick] : (k < 85) ? 32'hffff_ffff : $urandom();
            pool_next[pick] = b + 32'd1;
            send_access(pool_rel[pick], pool_spc[pick], pool_db[pick], f, b);
            counted++;
         end
         calm = 1'b0;
      end

      drain();
      repeat (200) @(posedge clock);
      if (verdict_q.size() != 0) report($sformatf("%0d verdicts never came", verdict_q.size()));
      $display("%0d accesses sent, %0d verdicts, %0d table hits, %0d judged sequential",
               words_in, words_out, hits_seen, seq_seen);
      $display("%0d register settings visited, %0d mismatches", phases.size() + 1, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
